FILE: rtl/core/cva_pkg.sv
package cva_pkg;

    // Widths fixed by the port list
    localparam int IN_W      = 9;
    localparam int OUT_W     = 26;
    localparam int IN_LIMIT  = 255;

    // Arctangent table, millionths of a degree, tan(a) = 2^-i
    localparam int TABLE_LEN = 14;
    localparam longint MICRO_PER_DEG = 1000000;
    localparam longint ATAN_MICRO [TABLE_LEN] = '{
        45000000, 26565000, 14036200, 7125020, 3576330, 1789910, 895174,
        447614, 223811, 111906, 55953, 27977, 13988, 6994
    };

    // floor(angle * 2^frac), evaluated at elaboration
    function automatic longint atan_entry(input int idx, input int frac);
        longint micro;
        micro = ATAN_MICRO[idx];
        return (micro <<< frac) / MICRO_PER_DEG;
    endfunction

endpackage

FILE: rtl/core/cva_step.sv
module cva_step #(
    parameter int W     = 28,
    parameter int AW    = 27,
    parameter int SHIFT = 0,
    parameter logic signed [AW-1:0] ANGLE = '0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_flag,
    input  logic signed [W-1:0]  in_cx,
    input  logic signed [W-1:0]  in_cy,
    input  logic signed [AW-1:0] in_acc,
    output logic                 out_valid,
    output logic                 out_flag,
    output logic signed [W-1:0]  out_cx,
    output logic signed [W-1:0]  out_cy,
    output logic signed [AW-1:0] out_acc
);
    logic                 valid_reg;
    logic                 flag_reg;
    logic signed [W-1:0]  cx_reg, cx_next;
    logic signed [W-1:0]  cy_reg, cy_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [W-1:0]  cx_sh, cy_sh;

    assign cx_sh = in_cx >>> SHIFT;
    assign cy_sh = in_cy >>> SHIFT;

    // rotate towards the positive first axis
    always_comb
    begin
        if (in_cy[W-1])
        begin
            cx_next  = in_cx - cy_sh;
            cy_next  = in_cy + cx_sh;
            acc_next = in_acc + ANGLE;
        end
        else
        begin
            cx_next  = in_cx + cy_sh;
            cy_next  = in_cy - cx_sh;
            acc_next = in_acc - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= in_flag;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        acc_reg  <= acc_next;
    end

    assign out_valid = valid_reg;
    assign out_flag  = flag_reg;
    assign out_cx    = cx_reg;
    assign out_cy    = cy_reg;
    assign out_acc   = acc_reg;

endmodule

FILE: rtl/core/cordic_vectoring_angle.sv
// Stages: one input stage, one register per CORDIC step (13 steps by default), one output.
// Throughput: one item per cycle; busy is never raised, every step has its own adders.
// Reset: rst_n clears the valid bits of all stages at once; items in flight are dropped.
// done strobes for one cycle with the angle; the receiver cannot stall.
module cordic_vectoring_angle #(
    parameter int ITERATIONS    = 13,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cva_pkg::IN_W-1:0]   vec_x,
    input  logic signed [cva_pkg::IN_W-1:0]   vec_y,
    output logic                              done,
    output logic signed [cva_pkg::OUT_W-1:0]  angle_deg_q16
);
    import cva_pkg::*;

    // Datapath width: |vector| grows to about 255 * sqrt(2) * 1.65 < 2^10,
    // so 11 integer bits plus sign plus the fraction.
    localparam int W  = FRACTION_BITS + 12;
    // Angle accumulator: +-1024 degrees, and at least as wide as the output.
    localparam int AW = (FRACTION_BITS + 11 > OUT_W) ? FRACTION_BITS + 11 : OUT_W;
    localparam longint ONE = longint'(1) <<< FRACTION_BITS;
    localparam logic signed [AW-1:0] ACC_INIT  = AW'(-90 * ONE);
    localparam logic signed [AW-1:0] FULL_TURN = AW'(360 * ONE);
    localparam logic signed [IN_W-1:0] IN_MIN  = IN_W'(-IN_LIMIT);

    // Pipeline buses; index 0 is the input stage, index ITERATIONS the last step
    logic                 v_pipe   [0:ITERATIONS];
    logic                 f_pipe   [0:ITERATIONS];
    logic signed [W-1:0]  cx_pipe  [0:ITERATIONS];
    logic signed [W-1:0]  cy_pipe  [0:ITERATIONS];
    logic signed [AW-1:0] acc_pipe [0:ITERATIONS];

    // ---------------- input stage ----------------
    // Saturation: only the pattern -256 lies outside +-255.
    // The vector is turned by -90 degrees: (x, y) -> (y, -x), accumulator at -90.
    // A negative y has its first coordinate negated and marks the item for +360.
    logic signed [IN_W-1:0] x_sat, y_sat;
    logic signed [W-1:0]    cx_start, cx0_next, cy0_next;
    logic                   in_valid_reg;
    logic                   in_flag_reg;
    logic signed [W-1:0]    in_cx_reg, in_cy_reg;

    always_comb
    begin
        x_sat    = (vec_x < IN_MIN) ? IN_MIN : vec_x;
        y_sat    = (vec_y < IN_MIN) ? IN_MIN : vec_y;
        cx_start = W'(y_sat) <<< FRACTION_BITS;
        cy0_next = -(W'(x_sat) <<< FRACTION_BITS);
        cx0_next = y_sat[IN_W-1] ? -cx_start : cx_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        in_flag_reg <= y_sat[IN_W-1];
        in_cx_reg   <= cx0_next;
        in_cy_reg   <= cy0_next;
    end

    assign v_pipe[0]   = in_valid_reg;
    assign f_pipe[0]   = in_flag_reg;
    assign cx_pipe[0]  = in_cx_reg;
    assign cy_pipe[0]  = in_cy_reg;
    assign acc_pipe[0] = ACC_INIT;

    // ---------------- CORDIC steps, one register stage each ----------------
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_step
        cva_step #(
            .W     (W),
            .AW    (AW),
            .SHIFT (i),
            .ANGLE (AW'(atan_entry(i, FRACTION_BITS)))
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_pipe[i]),
            .in_flag   (f_pipe[i]),
            .in_cx     (cx_pipe[i]),
            .in_cy     (cy_pipe[i]),
            .in_acc    (acc_pipe[i]),
            .out_valid (v_pipe[i+1]),
            .out_flag  (f_pipe[i+1]),
            .out_cx    (cx_pipe[i+1]),
            .out_cy    (cy_pipe[i+1]),
            .out_acc   (acc_pipe[i+1])
        );
    end

    // ---------------- output stage ----------------
    // Upper half plane: angle = -acc. Lower half: acc + 360, i.e. 180..360.
    // x and y magnitudes are not needed past the last step.
    logic signed [AW-1:0]    res;
    logic                    done_reg;
    logic signed [OUT_W-1:0] angle_reg;

    assign res = f_pipe[ITERATIONS] ? acc_pipe[ITERATIONS] + FULL_TURN
                                    : -acc_pipe[ITERATIONS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_pipe[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= res[OUT_W-1:0];
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign angle_deg_q16 = angle_reg;

    // ---------------- assertions ----------------
    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(ITERATIONS + 2) done)
        else $error("accepted item did not emerge after pipeline latency");

    // no result without an item accepted exactly one latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ITERATIONS + 2))
        else $error("result strobe without a matching accepted item");

    // the first pipeline stage only fills from an accepted item
    a_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        v_pipe[0] |-> $past(start))
        else $error("input stage valid without start");

endmodule
